// ===== src/olasd_pkg.sv =====
// shared types and constants for the ordered list store
// no dependencies; imported by the top level and the sweep sequencer
package olasd_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_DUMP   = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;
   localparam logic [1:0] ACT_DELETE = 2'd3;

   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_MISS = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [1:0]               status;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SWEEP,
      SEQ_DRAIN
   } seq_state_type;

   // sequencer to datapath
   typedef struct packed {
      logic              busy;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              dat_vld;
      logic [ADDR_W-1:0] dat_idx;
      logic              dat_last;
      logic [1:0]        act;
   } seq_ctl_type;

endpackage

// ===== src/ordered_list_append_search_delete.sv =====
// top level of the ordered list store: count, key, compare unit and result register
// depends on olasd_pkg, olasd_seq and olasd_ram
module ordered_list_append_search_delete
   import olasd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   // Insertion-ordered list of up to DEPTH signed 32-bit values held in one
   // simple dual-port ram. A request transfer happens on a clock edge with
   // start high and busy low. Append is done in the transfer cycle, busy
   // stays low and its result shows in the next cycle. Dump, search and delete
   // on a non-empty list sweep the stored entries through the single ram read
   // port, one entry a cycle, so busy stays high through the sweep and drain
   // states and the (last) result shows in the first cycle with busy low; a
   // dump gives one result per entry on consecutive cycles ending with that one.
   // On an empty list these give one result in the cycle after the transfer.
   // Results are held for exactly one cycle on rsp_strobe and cannot be
   // stalled by the receiver. Ram contents need no clearing pass after reset:
   // only entries below the count are ever read.

   seq_ctl_type              ctl;
   logic                     accept;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] key_ff;
   logic                     found_ff, found_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_type                  rsp_item_ff, rsp_item_in;
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic [DATA_W-1:0]        ram_rd_data;
   logic                     hit;
   logic                     found_now;

   assign accept = start && !ctl.busy;
   assign busy   = ctl.busy;

   olasd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_item.action),
      .count      (count_ff),
      .ctl        (ctl)
   );

   olasd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_addr),
      .rd_data (ram_rd_data)
   );

   // the one shared compare unit, used on every entry a search or delete sweep returns
   assign hit       = (ram_rd_data == key_ff);
   assign found_now = found_ff || hit;

   always_comb begin
      count_in      = count_ff;
      found_in      = found_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '{result_value: '0, status: STS_OK, last: 1'b1};
      ram_we        = 1'b0;
      ram_wr_addr   = count_ff[ADDR_W-1:0];
      ram_wr_data   = req_item.value;

      if (accept) begin
         found_in = 1'b0;
         unique case (req_item.action)
            ACT_APPEND: begin
               rsp_strobe_in = 1'b1;
               if (count_ff == CNT_W'(DEPTH)) begin
                  rsp_item_in.status = STS_FULL;
               end else begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_DUMP, ACT_SEARCH, ACT_DELETE: begin
               // empty list answers at once, otherwise the sweep does it
               if (count_ff == '0) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_item_in.status = STS_MISS;
               end
            end
            default: begin
               rsp_strobe_in = 1'b0;
            end
         endcase
      end else if (ctl.dat_vld) begin
         if (ctl.act == ACT_DUMP) begin
            // every entry goes out in order
            rsp_strobe_in            = 1'b1;
            rsp_item_in.result_value = ram_rd_data;
            rsp_item_in.last         = ctl.dat_last;
         end else begin
            if (!found_ff && hit) begin
               found_in = 1'b1;
            end else if (found_ff && (ctl.act == ACT_DELETE)) begin
               // close the gap: entries behind the match move down by one
               ram_we      = 1'b1;
               ram_wr_addr = ctl.dat_idx - ADDR_W'(1);
               ram_wr_data = ram_rd_data;
            end
            if (ctl.dat_last) begin
               rsp_strobe_in = 1'b1;
               if (found_now) begin
                  rsp_item_in.result_value = key_ff;
                  if (ctl.act == ACT_DELETE) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end else begin
                  rsp_item_in.status = STS_MISS;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (accept) begin
         key_ff <= req_item.value;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTHESIS
   // the entry count never passes the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // returned sweep data only while the sequencer is busy
   a_data_in_sweep: assert property (@(posedge clock) disable iff (reset)
      ctl.dat_vld |-> ctl.busy)
      else $error("ram data returned outside a sweep");

   // ram written only by an append transfer or by a delete shift
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (accept || (ctl.dat_vld && ctl.act == ACT_DELETE)))
      else $error("unexpected ram write");

   // the count only drops with a successful delete result
   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff < $past(count_ff)))
         |-> (rsp_strobe && (rsp_item.status == STS_OK)))
      else $error("count dropped without a delete result");
`endif

endmodule

// ===== src/olasd_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module olasd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/olasd_seq.sv =====
// sweep sequencer: walks the stored entries one read per cycle
// depends on olasd_pkg
module olasd_seq
   import olasd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_action,
   input  logic [CNT_W-1:0] count,
   output seq_ctl_type      ctl
);

   seq_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              dat_vld_ff;
   logic [ADDR_W-1:0] dat_idx_ff;
   logic [1:0]        act_ff;
   logic              accept;
   logic              at_end;
   logic              rd_en;

   assign accept = start && (state_ff == SEQ_IDLE);
   assign at_end = (CNT_W'(idx_ff) == count - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            idx_in = '0;
            if (accept && (req_action != ACT_APPEND) && (count != '0)) begin
               state_in = SEQ_SWEEP;
            end
         end
         SEQ_SWEEP: begin
            idx_in = idx_ff + ADDR_W'(1);
            if (at_end) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      rd_en        = (state_ff == SEQ_SWEEP);
      ctl.busy     = (state_ff != SEQ_IDLE);
      ctl.rd_en    = rd_en;
      ctl.rd_addr  = idx_ff;
      ctl.dat_vld  = dat_vld_ff;
      ctl.dat_idx  = dat_idx_ff;
      ctl.dat_last = dat_vld_ff && (CNT_W'(dat_idx_ff) == count - CNT_W'(1));
      ctl.act      = act_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         idx_ff     <= '0;
         dat_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         dat_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      dat_idx_ff <= idx_ff;
      if (accept) begin
         act_ff <= req_action;
      end
   end

endmodule

// ===== tb/sv/ordered_list_append_search_delete_tb.sv =====
// self-checking testbench for the ordered list store: directed then random commands
// depends on olasd_pkg and ordered_list_append_search_delete; a class mirrors the list
module ordered_list_append_search_delete_tb;
   import olasd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 1000;    // cycles with no transfer before giving up
   localparam int TAIL_CYCLES  = 3 * DEPTH;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 18;

   // mirror of the list contents and the results each command should give
   class list_mirror;
      logic signed [DATA_W-1:0] slots[DEPTH];
      int                       fill;
      rsp_type                  pending_rsps[$];
      int                       mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      function void push_rsp(logic signed [DATA_W-1:0] v, logic [1:0] s, logic l);
         rsp_type r;
         r.result_value = v;
         r.status       = s;
         r.last         = l;
         pending_rsps.push_back(r);
      endfunction

      // oldest slot holding v, or fill when absent
      function int find_first(logic signed [DATA_W-1:0] v);
         for (int i = 0; i < fill; i++) begin
            if (slots[i] == v) return i;
         end
         return fill;
      endfunction

      function void note_request(req_type rq);
         int pos;
         case (rq.action)
            ACT_APPEND: begin
               if (fill >= DEPTH) begin
                  push_rsp('0, STS_FULL, 1'b1);
               end else begin
                  slots[fill] = rq.value;
                  fill++;
                  push_rsp('0, STS_OK, 1'b1);
               end
            end
            ACT_DUMP: begin
               if (fill == 0) begin
                  push_rsp('0, STS_MISS, 1'b1);
               end else begin
                  for (int i = 0; i < fill; i++) begin
                     push_rsp(slots[i], STS_OK, i == fill - 1);
                  end
               end
            end
            ACT_SEARCH: begin
               pos = find_first(rq.value);
               if (pos < fill) push_rsp(slots[pos], STS_OK, 1'b1);
               else push_rsp('0, STS_MISS, 1'b1);
            end
            default: begin
               pos = find_first(rq.value);
               if (pos < fill) begin
                  push_rsp(slots[pos], STS_OK, 1'b1);
                  for (int i = pos; i < fill - 1; i++) begin
                     slots[i] = slots[i + 1];
                  end
                  fill--;
               end else begin
                  push_rsp('0, STS_MISS, 1'b1);
               end
            end
         endcase
      endfunction

      task check_rsp(rsp_type got);
         rsp_type want;
         if (pending_rsps.size() == 0) begin
            report($sformatf("unexpected result value %0d status %0d last %0d",
                             got.result_value, got.status, got.last));
         end else begin
            want = pending_rsps.pop_front();
            if (got.result_value !== want.result_value) begin
               report($sformatf("result_value %0d, wanted %0d",
                                got.result_value, want.result_value));
            end
            if (got.status !== want.status) begin
               report($sformatf("status %0d, wanted %0d", got.status, want.status));
            end
            if (got.last !== want.last) begin
               report($sformatf("last %0d, wanted %0d", got.last, want.last));
            end
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   list_mirror mirror;
   int         idle_cycles;
   bit         gaps_on;
   logic signed [DATA_W-1:0] value_pool[8];

   ordered_list_append_search_delete DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // results are checked before the new command is noted; a command cannot
   // produce its own result on the edge that accepts it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) mirror.check_rsp(rsp_item);
         if (start && !busy) mirror.note_request(req_item);
      end
   end

   // watchdog: any input or result transfer resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one command transfer; start stays high afterwards so back-to-back
   // commands never drop and raise it within one time step
   task send_cmd(logic [1:0] act, logic signed [DATA_W-1:0] val);
      req_type rq;
      int      gap;
      rq.action = act;
      rq.value  = val;
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= rq;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   // mostly values from a small pool so that searches and deletes hit,
   // otherwise any 32-bit pattern
   function logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   initial begin
      int roll;
      logic [1:0] act;
      bit filling;

      mirror      = new();
      idle_cycles = 0;
      gaps_on     = 1'b1;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;

      value_pool[0] = 32'sh7FFF_FFFF;
      value_pool[1] = 32'sh8000_0000;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list: dump gives one empty result, delete misses
      send_cmd(ACT_DUMP, $urandom);
      send_cmd(ACT_DELETE, 32'sh0000_0001);

      // extremes and a duplicate of the oldest entry
      send_cmd(ACT_APPEND, 32'sh7FFF_FFFF);
      send_cmd(ACT_APPEND, 32'sh8000_0000);
      send_cmd(ACT_APPEND, -1);
      send_cmd(ACT_APPEND, 32'sh7FFF_FFFF);
      send_cmd(ACT_DUMP, '0);
      send_cmd(ACT_SEARCH, 32'sh7FFF_FFFF);
      send_cmd(ACT_SEARCH, '0);

      // delete takes the oldest duplicate; the order of the rest is kept
      send_cmd(ACT_DELETE, 32'sh7FFF_FFFF);

      // fill to capacity, then one append too many
      for (int i = 0; i < DEPTH - 3; i++) send_cmd(ACT_APPEND, $urandom);
      send_cmd(ACT_APPEND, 32'sh5555_AAAA);
      send_cmd(ACT_DUMP, $urandom);

      // random phases alternate between filling and draining the list
      filling = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (filling) begin
               act = (roll < 55) ? ACT_APPEND : (roll < 70) ? ACT_DUMP :
                     (roll < 85) ? ACT_SEARCH : ACT_DELETE;
            end else begin
               act = (roll < 15) ? ACT_APPEND : (roll < 30) ? ACT_DUMP :
                     (roll < 50) ? ACT_SEARCH : ACT_DELETE;
            end
            send_cmd(act, pick_value());
         end
         filling = !filling;
      end
      start <= 1'b0;

      // drain: the watchdog guards this wait
      while (mirror.pending_rsps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mirror.pending_rsps.size() != 0) begin
         mirror.report($sformatf("%0d results never arrived", mirror.pending_rsps.size()));
      end
      if (mirror.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
